>>> rtl/bmmd_pkg.sv
// Shared types and constants for the banked memory map decoder.
// No dependencies; every other file in rtl/ imports this package.
package bmmd_pkg;

  // Fixed sizes of the internal RAMs in bytes, plus the byte width and the ROM address width.
  localparam int unsigned VRAM_BYTES      = 8192;
  localparam int unsigned WRAM_BANK_BYTES = 4096;
  localparam int unsigned HRAM_BYTES      = 127;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned ROM_ADDR_W      = 19;

  // Where an access ends up.
  typedef enum logic [2:0] {
    TGT_BOOT    = 3'd0,
    TGT_CART    = 3'd1,
    TGT_RAM     = 3'd2,
    TGT_IO      = 3'd3,
    TGT_OAM     = 3'd4,
    TGT_REFUSED = 3'd5,
    TGT_FAULT   = 3'd6
  } target_e;

  // Which internal RAM an access touches.
  typedef enum logic [1:0] {
    RAM_NONE = 2'd0,
    RAM_VRAM = 2'd1,
    RAM_WRAM = 2'd2,
    RAM_HRAM = 2'd3
  } ram_sel_e;

  // Decoded view of one bus access.
  typedef struct packed {
    target_e                 target;
    logic [ROM_ADDR_W-1:0]   rom_address;
    logic [7:0]              reg_index;
    logic                    accepted;
    ram_sel_e                ram_sel;
    logic                    set_bank;
    logic                    clear_boot;
  } dec_t;

endpackage

>>> rtl/banked_memory_map_decoder.sv
// Top level of the banked memory map decoder: bus access stream in, decode
// result stream out. Depends on bmmd_pkg, bmmd_decode and bmmd_ram.
//
// Usage:
// - Slave stream s_axis_*: one bus access per transfer; tuser is the access
//   kind (0 read, 1 write), tdata carries the address and the write byte.
// - Master stream m_axis_*: one result per access; tuser is the target code,
//   tdata carries ROM address, register index, read byte and accepted flag.
// - cfg_we_i/cfg_wdata_i write the work RAM bank seen at 0xD000-0xDFFF.
//   Write it only while no access is in flight.
// - One access is taken every cycle while the receiver does not stall: the
//   decode and the RAM port access happen in the accept cycle, and the RAM
//   read register plus the output register give the result in the next.
// - Reset sets the ROM bank to one, maps the boot ROM and selects work RAM
//   bank one. The RAMs are not cleared and hold no valid state after reset;
//   there is no clearing pass.
// - When the receiver stalls, the result holds and s_axis_tready drops;
//   a new access is taken in the same cycle the held result is transferred.
module banked_memory_map_decoder import bmmd_pkg::*; #(
  parameter int unsigned WRAM_BANKS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: work RAM bank.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  // Access stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [15:0] address, [23:16] write_data
  input  logic [0:0]  s_axis_tuser,  // [0] func
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [18:0] rom_address, [26:19] reg_index,
                                     // [34:27] read_data, [35] accepted, zero above
  output logic [2:0]  m_axis_tuser   // [2:0] target
);

  localparam int unsigned WRAM_DEPTH = WRAM_BANKS * WRAM_BANK_BYTES;
  localparam int unsigned WRAM_AW    = $clog2(WRAM_DEPTH);
  localparam int unsigned OFF_W      = $clog2(WRAM_BANK_BYTES);
  localparam int unsigned WB_W       = WRAM_AW - OFF_W;
  localparam int unsigned VRAM_AW    = $clog2(VRAM_BYTES);
  localparam int unsigned HRAM_AW    = $clog2(HRAM_BYTES);
  localparam logic [3:0]  NBANKS     = 4'(WRAM_BANKS);

  // Reduce a bank number below the bank count by repeated subtraction.
  function automatic logic [2:0] bank_mod(input logic [2:0] v);
    logic [3:0] r;
    r = {1'b0, v};
    for (int i = 0; i < 4; i++) begin
      if (r >= NBANKS) begin
        r = r - NBANKS;
      end
    end
    return r[2:0];
  endfunction

  logic        in_fire;
  logic        is_write;
  logic [15:0] address;
  logic [7:0]  write_data;
  dec_t        dec;

  logic [4:0]  rom_bank_q, rom_bank_d;
  logic        boot_overlay_q, boot_overlay_d;
  logic [2:0]  wram_bank_q, wram_bank_d;

  logic                  out_valid_q, out_valid_d;
  target_e               out_target_q;
  logic [ROM_ADDR_W-1:0] out_rom_q;
  logic [7:0]            out_reg_q;
  logic                  out_ok_q;
  ram_sel_e              out_sel_q;

  logic [BYTE_W-1:0] vram_rdata, wram_rdata, hram_rdata;
  logic [BYTE_W-1:0] read_data;
  logic [WB_W-1:0]   wram_bank_sel;
  logic [WRAM_AW-1:0] wram_addr;

  assign is_write   = s_axis_tuser[0];
  assign address    = s_axis_tdata[15:0];
  assign write_data = s_axis_tdata[23:16];

  // The output register frees when empty or when its result transfers.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  bmmd_decode u_decode (
    .is_write_i     (is_write),
    .address_i      (address),
    .rom_bank_i     (rom_bank_q),
    .boot_overlay_i (boot_overlay_q),
    .dec_o          (dec)
  );

  // Banking registers and configuration.
  always_comb begin
    rom_bank_d     = rom_bank_q;
    boot_overlay_d = boot_overlay_q;
    wram_bank_d    = wram_bank_q;
    if (in_fire && dec.set_bank) begin
      rom_bank_d = write_data[4:0];
    end
    if (in_fire && dec.clear_boot) begin
      boot_overlay_d = 1'b0;
    end
    if (cfg_we_i) begin
      wram_bank_d = bank_mod(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_bank_q     <= 5'd1;
      boot_overlay_q <= 1'b1;
      wram_bank_q    <= bank_mod(3'd1);
    end else begin
      rom_bank_q     <= rom_bank_d;
      boot_overlay_q <= boot_overlay_d;
      wram_bank_q    <= wram_bank_d;
    end
  end

  // Work RAM: the lower window is always bank zero.
  assign wram_bank_sel = address[OFF_W] ? wram_bank_q[WB_W-1:0] : '0;
  assign wram_addr     = {wram_bank_sel, address[OFF_W-1:0]};

  bmmd_ram #(.DEPTH(VRAM_BYTES)) u_vram (
    .clk_i   (clk_i),
    .en_i    (in_fire && dec.ram_sel == RAM_VRAM),
    .we_i    (is_write),
    .addr_i  (address[VRAM_AW-1:0]),
    .wdata_i (write_data),
    .rdata_o (vram_rdata)
  );

  bmmd_ram #(.DEPTH(WRAM_DEPTH)) u_wram (
    .clk_i   (clk_i),
    .en_i    (in_fire && dec.ram_sel == RAM_WRAM),
    .we_i    (is_write),
    .addr_i  (wram_addr),
    .wdata_i (write_data),
    .rdata_o (wram_rdata)
  );

  bmmd_ram #(.DEPTH(HRAM_BYTES)) u_hram (
    .clk_i   (clk_i),
    .en_i    (in_fire && dec.ram_sel == RAM_HRAM),
    .we_i    (is_write),
    .addr_i  (address[HRAM_AW-1:0]),
    .wdata_i (write_data),
    .rdata_o (hram_rdata)
  );

  // Output register control.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload; a write leaves the select at none so no byte shows.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_target_q <= dec.target;
      out_rom_q    <= dec.rom_address;
      out_reg_q    <= dec.reg_index;
      out_ok_q     <= dec.accepted;
      out_sel_q    <= is_write ? RAM_NONE : dec.ram_sel;
    end
  end

  // RAM read registers hold until the next read, so the byte stays put
  // while the result waits.
  always_comb begin
    case (out_sel_q)
      RAM_VRAM: read_data = vram_rdata;
      RAM_WRAM: read_data = wram_rdata;
      RAM_HRAM: read_data = hram_rdata;
      default:  read_data = '0;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_target_q;
  assign m_axis_tdata  = {4'b0000, out_ok_q, read_data, out_reg_q, out_rom_q};

  // Every accepted access shows a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> m_axis_tvalid)
    else $error("accepted access produced no result");

  // The boot-off write unmaps the boot ROM.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_write && address == 16'hFF50) |=> !boot_overlay_q)
    else $error("boot overlay still set after boot-off write");

  // The boot ROM is only targeted while the overlay is set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && dec.target == TGT_BOOT) |-> boot_overlay_q)
    else $error("boot ROM target without overlay");

  // The accepted flag agrees with the target code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_ok_q ==
      (out_target_q != TGT_REFUSED && out_target_q != TGT_FAULT)))
    else $error("accepted flag disagrees with target");

  // Read data is zero unless the result is an internal RAM access.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_target_q != TGT_RAM) |-> (read_data == '0))
    else $error("read data set for a non-RAM target");

endmodule

>>> rtl/bmmd_ram.sv
// Single-port byte RAM with a registered read port.
// Depends on bmmd_pkg for the data width.
module bmmd_ram import bmmd_pkg::*; #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [AW-1:0]     addr_i,
  input  logic [BYTE_W-1:0] wdata_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  // A write stores the byte; a read updates the output register, which
  // otherwise holds its last value.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bmmd_decode.sv
// Combinational address decoder for the memory map.
// Depends on bmmd_pkg for the target codes and the decode struct.
module bmmd_decode import bmmd_pkg::*; (
  input  logic        is_write_i,
  input  logic [15:0] address_i,
  input  logic [4:0]  rom_bank_i,
  input  logic        boot_overlay_i,
  output dec_t        dec_o
);

  localparam int unsigned VRAM_BASE = 32'h8000;
  localparam int unsigned WRAM_BASE = 32'hC000;
  localparam int unsigned WRAM_END  = 32'hE000;
  localparam int unsigned OAM_BASE  = 32'hFE00;
  localparam int unsigned OAM_END   = 32'hFEA0;
  localparam int unsigned IO_BASE   = 32'hFF00;
  localparam int unsigned HRAM_BASE = 32'hFF80;
  localparam int unsigned BOOT_END  = 32'h0100;
  localparam int unsigned BANK_BASE = 32'h2000;
  localparam int unsigned BANK0_END = 32'h4000;
  localparam int unsigned ROM_END   = 32'h8000;
  localparam logic [15:0] BOOT_OFF  = 16'hFF50;

  // I/O registers that may be read.
  function automatic logic io_readable(input logic [15:0] a);
    logic r;
    unique case (a) inside
      16'hFF00, 16'hFF24, 16'hFF40, 16'hFF42, 16'hFF44, 16'hFFFF: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // I/O registers that may be written.
  function automatic logic io_writable(input logic [15:0] a);
    logic r;
    unique case (a) inside
      16'hFF00, 16'hFF06, 16'hFF07, 16'hFF0F,
      16'hFF10, 16'hFF11, 16'hFF12, 16'hFF13, 16'hFF14,
      16'hFF17, 16'hFF19, 16'hFF1A, 16'hFF21,
      16'hFF23, 16'hFF24, 16'hFF25, 16'hFF26,
      16'hFF40, 16'hFF41, 16'hFF42, 16'hFF43,
      16'hFF46, 16'hFF47, 16'hFF48, 16'hFF49,
      16'hFF4A, 16'hFF4B, 16'hFF50, 16'hFFFF: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  logic [4:0] bank_eff;

  // Bank zero in the switched window maps to bank one.
  assign bank_eff = (rom_bank_i == 5'd0) ? 5'd1 : rom_bank_i;

  always_comb begin
    dec_o             = '0;
    dec_o.target      = TGT_FAULT;
    dec_o.ram_sel     = RAM_NONE;

    if (address_i >= VRAM_BASE && address_i < VRAM_BASE + VRAM_BYTES) begin
      dec_o.target   = TGT_RAM;
      dec_o.accepted = 1'b1;
      dec_o.ram_sel  = RAM_VRAM;
    end else if (address_i >= WRAM_BASE && address_i < WRAM_END) begin
      dec_o.target   = TGT_RAM;
      dec_o.accepted = 1'b1;
      dec_o.ram_sel  = RAM_WRAM;
    end else if (address_i >= HRAM_BASE && address_i < HRAM_BASE + HRAM_BYTES) begin
      dec_o.target   = TGT_RAM;
      dec_o.accepted = 1'b1;
      dec_o.ram_sel  = RAM_HRAM;
    end else if (!is_write_i) begin
      // Reads: ROM windows and readable I/O.
      if (address_i < BOOT_END) begin
        dec_o.target      = boot_overlay_i ? TGT_BOOT : TGT_CART;
        dec_o.rom_address = {3'b000, address_i};
        dec_o.accepted    = 1'b1;
      end else if (address_i < BANK0_END) begin
        dec_o.target      = TGT_CART;
        dec_o.rom_address = {3'b000, address_i};
        dec_o.accepted    = 1'b1;
      end else if (address_i < ROM_END) begin
        dec_o.target      = TGT_CART;
        dec_o.rom_address = {bank_eff, address_i[13:0]};
        dec_o.accepted    = 1'b1;
      end else if (io_readable(address_i)) begin
        dec_o.target    = TGT_IO;
        dec_o.reg_index = address_i[7:0];
        dec_o.accepted  = 1'b1;
      end
    end else begin
      // Writes: bank select, OAM, refused holes and writable I/O.
      if (address_i >= BANK_BASE && address_i < BANK0_END) begin
        dec_o.target   = TGT_CART;
        dec_o.accepted = 1'b1;
        dec_o.set_bank = 1'b1;
      end else if (address_i >= OAM_BASE && address_i < OAM_END) begin
        dec_o.target    = TGT_OAM;
        dec_o.reg_index = address_i[7:0];
        dec_o.accepted  = 1'b1;
      end else if ((address_i >= OAM_END && address_i < IO_BASE) ||
                   address_i == 16'hFF01 || address_i == 16'hFF02 ||
                   address_i == 16'hFF7F) begin
        dec_o.target = TGT_REFUSED;
      end else if (io_writable(address_i)) begin
        dec_o.target     = TGT_IO;
        dec_o.reg_index  = address_i[7:0];
        dec_o.accepted   = 1'b1;
        dec_o.clear_boot = (address_i == BOOT_OFF);
      end
    end
  end

endmodule
